// ===== sv/vlc_device_association_fsm_macros.svh =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: assertion macros
// Property wrappers clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef VLC_DEVICE_ASSOCIATION_FSM_MACROS_SVH
`define VLC_DEVICE_ASSOCIATION_FSM_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define VDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vda assertion failed");

// next-cycle implication
`define VDA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vda assertion failed");

`else

`define VDA_ASSERT_IMP(lbl, ante, cons)
`define VDA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/vda_pkg.sv =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: package
// Word types, state and configuration records and command, action, status, phase and register index codes.
// ---------------------------------------------------------------------------
`default_nettype none

package vda_pkg;

    // command codes
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_TX_RESULT = 3'd1;
    localparam logic [2:0] CMD_BEACON    = 3'd2;
    localparam logic [2:0] CMD_GRANT     = 3'd3;
    localparam logic [2:0] CMD_RESP      = 3'd4;
    localparam logic [2:0] CMD_TICK      = 3'd5;

    // actions
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_ASSOC_REQ  = 3'd1;
    localparam logic [2:0] ACT_DATA_REQ   = 3'd2;
    localparam logic [2:0] ACT_RX_SLOT    = 3'd3;
    localparam logic [2:0] ACT_ACK_SLOT   = 3'd4;
    localparam logic [2:0] ACT_SEND_ACK   = 3'd5;
    localparam logic [2:0] ACT_CONFIRM    = 3'd6;

    // confirm status
    localparam logic [2:0] ST_SUCCESS     = 3'd0;
    localparam logic [2:0] ST_ACCESS_FAIL = 3'd1;
    localparam logic [2:0] ST_NO_ACK      = 3'd2;
    localparam logic [2:0] ST_NO_DATA     = 3'd3;
    localparam logic [2:0] ST_DENIED      = 3'd4;

    // tx status and response status
    localparam logic [1:0] TX_SUCCESS     = 2'd0;
    localparam logic [1:0] TX_ACCESS_FAIL = 2'd1;
    localparam logic [1:0] RESP_SUCCESS   = 2'd0;

    // phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_TX_REQ    = 4'd1;
    localparam logic [3:0] PH_BEACON    = 4'd2;
    localparam logic [3:0] PH_POLL      = 4'd3;
    localparam logic [3:0] PH_TX_DATA   = 4'd4;
    localparam logic [3:0] PH_RX_GRANT  = 4'd5;
    localparam logic [3:0] PH_RESP      = 4'd6;
    localparam logic [3:0] PH_ACK_GRANT = 4'd7;
    localparam logic [3:0] PH_TX_ACK    = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_TRACK_BEACON = 2'd0;
    localparam logic [1:0] CFG_BEACON_WAIT  = 2'd1;
    localparam logic [1:0] CFG_POLL_WAIT    = 2'd2;

    localparam logic [23:0] BEACON_WAIT_RST = 24'd32;
    localparam logic [23:0] POLL_WAIT_RST   = 24'd30720;
    localparam logic [15:0] NO_ADDR         = 16'hffff;
    localparam logic [7:0]  NO_CHANNEL      = 8'hff;
    localparam logic [15:0] NO_NET_ID       = 16'h00ff;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  channel;
        logic [15:0] net_id;
        logic [63:0] coord_addr;
        logic [1:0]  coord_addr_mode;
        logic [1:0]  tx_status;
        logic        ack_pending;
        logic        listed_in_beacon;
        logic [1:0]  resp_status;
        logic [15:0] resp_short_addr;
        logic [63:0] resp_coord_ext;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] dest_addr;
        logic [15:0] dest_net_id;
        logic [7:0]  use_channel;
        logic [2:0]  confirm_status;
        logic [15:0] short_addr;
        logic [63:0] coord_ext_addr;
        logic        busy_res;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  saved_channel;
        logic [15:0] saved_net_id;
        logic [63:0] saved_coord;
        logic [23:0] wait_count;
        logic [15:0] given_addr;
        logic        resp_denied;
        logic [63:0] learned_ext;
    } t_state;

    typedef struct packed {
        logic        track_beacon;
        logic [23:0] beacon_wait_ticks;
        logic [23:0] poll_wait_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/vda_in_if.sv =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: event channel
// Valid/ready channel carrying one event word.
// ---------------------------------------------------------------------------
`default_nettype none

interface vda_in_if;
    logic              valid;
    logic              ready;
    vda_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/vda_out_if.sv =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: result channel
// Valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface vda_out_if;
    logic               valid;
    logic               ready;
    vda_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/vda_step.sv =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: step logic
// Next state and result word for one event against the current state.
// ---------------------------------------------------------------------------
`default_nettype none

module vda_step (
    input  vda_pkg::t_state    i_state,
    input  vda_pkg::t_cfg      i_cfg,
    input  vda_pkg::t_in_word  i_word,
    output vda_pkg::t_state    o_state,
    output vda_pkg::t_out_word o_res
);

    logic [23:0] w_cnt_inc;
    logic [23:0] w_limit;
    logic        w_timer_hit;
    logic [2:0]  w_fail_code;
    logic        w_fin;
    logic [2:0]  w_fin_status;
    logic        w_fill;
    vda_pkg::t_state    n_state;
    vda_pkg::t_out_word n_res;

    assign w_cnt_inc   = i_state.wait_count + 24'd1;
    assign w_limit     = (i_state.phase == vda_pkg::PH_BEACON) ? i_cfg.beacon_wait_ticks
                                                               : i_cfg.poll_wait_ticks;
    assign w_timer_hit = (w_cnt_inc >= w_limit);
    assign w_fail_code = (i_word.tx_status == vda_pkg::TX_ACCESS_FAIL) ? vda_pkg::ST_ACCESS_FAIL
                                                                       : vda_pkg::ST_NO_ACK;

    always_comb begin
        n_state      = i_state;
        w_fin        = 1'b0;
        w_fin_status = vda_pkg::ST_SUCCESS;
        w_fill       = 1'b0;

        n_res                = '0;
        n_res.action         = vda_pkg::ACT_NONE;
        n_res.short_addr     = vda_pkg::NO_ADDR;

        case (i_word.cmd)
            vda_pkg::CMD_START: begin
                if (i_state.phase == vda_pkg::PH_IDLE) begin
                    n_state.saved_channel = i_word.channel;
                    n_state.saved_net_id  = i_word.net_id;
                    n_state.saved_coord   = i_word.coord_addr;
                    n_state.phase         = vda_pkg::PH_TX_REQ;
                    n_res.action          = vda_pkg::ACT_ASSOC_REQ;
                    w_fill                = 1'b1;
                end
            end
            vda_pkg::CMD_TX_RESULT: begin
                case (i_state.phase)
                    vda_pkg::PH_TX_REQ: begin
                        if (i_word.tx_status == vda_pkg::TX_SUCCESS) begin
                            n_state.wait_count = '0;
                            n_state.phase      = i_cfg.track_beacon ? vda_pkg::PH_BEACON
                                                                    : vda_pkg::PH_POLL;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_status = w_fail_code;
                        end
                    end
                    vda_pkg::PH_TX_DATA: begin
                        if (i_word.tx_status != vda_pkg::TX_SUCCESS) begin
                            w_fin        = 1'b1;
                            w_fin_status = w_fail_code;
                        end else if (i_word.ack_pending) begin
                            n_state.phase = vda_pkg::PH_RX_GRANT;
                            n_res.action  = vda_pkg::ACT_RX_SLOT;
                            w_fill        = 1'b1;
                        end else begin
                            w_fin        = 1'b1;
                            w_fin_status = vda_pkg::ST_NO_DATA;
                        end
                    end
                    vda_pkg::PH_TX_ACK: begin
                        w_fin        = 1'b1;
                        w_fin_status = i_state.resp_denied ? vda_pkg::ST_DENIED
                                                           : vda_pkg::ST_SUCCESS;
                    end
                    default: ;
                endcase
            end
            vda_pkg::CMD_BEACON: begin
                if (i_state.phase == vda_pkg::PH_BEACON && i_word.listed_in_beacon) begin
                    n_state.wait_count = '0;
                    n_state.phase      = vda_pkg::PH_TX_DATA;
                    n_res.action       = vda_pkg::ACT_DATA_REQ;
                    w_fill             = 1'b1;
                end
            end
            vda_pkg::CMD_GRANT: begin
                if (i_state.phase == vda_pkg::PH_RX_GRANT) begin
                    n_state.phase = vda_pkg::PH_RESP;
                end else if (i_state.phase == vda_pkg::PH_ACK_GRANT) begin
                    n_state.phase = vda_pkg::PH_TX_ACK;
                    n_res.action  = vda_pkg::ACT_SEND_ACK;
                    w_fill        = 1'b1;
                end
            end
            vda_pkg::CMD_RESP: begin
                if (i_state.phase == vda_pkg::PH_RESP) begin
                    if (i_word.resp_status == vda_pkg::RESP_SUCCESS) begin
                        n_state.given_addr  = i_word.resp_short_addr;
                        n_state.learned_ext = i_word.resp_coord_ext;
                        n_state.resp_denied = 1'b0;
                    end else begin
                        n_state.given_addr  = vda_pkg::NO_ADDR;
                        n_state.resp_denied = 1'b1;
                    end
                    n_state.phase = vda_pkg::PH_ACK_GRANT;
                    n_res.action  = vda_pkg::ACT_ACK_SLOT;
                    w_fill        = 1'b1;
                end
            end
            vda_pkg::CMD_TICK: begin
                if (i_state.phase == vda_pkg::PH_BEACON) begin
                    n_state.wait_count = w_cnt_inc;
                    if (w_timer_hit) begin
                        w_fin        = 1'b1;
                        w_fin_status = vda_pkg::ST_NO_DATA;
                    end
                end else if (i_state.phase == vda_pkg::PH_POLL) begin
                    n_state.wait_count = w_cnt_inc;
                    if (w_timer_hit) begin
                        n_state.wait_count = '0;
                        n_state.phase      = vda_pkg::PH_TX_DATA;
                        n_res.action       = vda_pkg::ACT_DATA_REQ;
                        w_fill             = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // confirm ends the session
        if (w_fin) begin
            n_res.action         = vda_pkg::ACT_CONFIRM;
            n_res.confirm_status = w_fin_status;
            if (w_fin_status == vda_pkg::ST_SUCCESS) begin
                w_fill           = 1'b1;
                n_res.short_addr = i_state.given_addr;
            end
            n_state.phase         = vda_pkg::PH_IDLE;
            n_state.saved_channel = vda_pkg::NO_CHANNEL;
            n_state.saved_net_id  = vda_pkg::NO_NET_ID;
            n_state.wait_count    = '0;
            n_state.given_addr    = vda_pkg::NO_ADDR;
            n_state.resp_denied   = 1'b0;
        end

        // start fills from the new word, all else from the held session
        if (w_fill) begin
            if (i_word.cmd == vda_pkg::CMD_START) begin
                n_res.dest_addr   = i_word.coord_addr;
                n_res.dest_net_id = i_word.net_id;
                n_res.use_channel = i_word.channel;
            end else begin
                n_res.dest_addr   = i_state.saved_coord;
                n_res.dest_net_id = i_state.saved_net_id;
                n_res.use_channel = i_state.saved_channel;
            end
        end

        n_res.coord_ext_addr = n_state.learned_ext;
        n_res.busy_res       = (n_state.phase != vda_pkg::PH_IDLE);
    end

    assign o_state = n_state;
    assign o_res   = n_res;

endmodule

`default_nettype wire

// ===== sv/vlc_device_association_fsm.sv =====
// ---------------------------------------------------------------------------
// VLC device association sequencer: top level
// Device-side association procedure driven by MAC events and ticks.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one event word (start, tx result, beacon, slot grant,
//   association response or tick); o_out returns exactly one result word per
//   event: the action to take, addressing, confirm status, short address and
//   the busy flag after the event.
//   Configuration is written on i_cfg_we with i_cfg_idx / i_cfg_data; the
//   user must do so only while the block is idle, which it does not enforce;
//   indexes beyond the register list are ignored. The event is registered,
//   then evaluated against the session state; the result word is registered.
//   Throughput: one event per cycle while o_out takes its words, with the
//   state updated between the event register and the result register.
//   A stalled o_out holds its word; the event register still takes one more
//   word, then i_in.ready drops until the result is taken.
//   Reset returns the session to idle, channel 255, network id 255, short
//   address 65535, wait registers to 32 and 30720 ticks, polling mode.
// ---------------------------------------------------------------------------
`default_nettype none

module vlc_device_association_fsm (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    vda_in_if.sink           i_in,
    vda_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    `include "vlc_device_association_fsm_macros.svh"

    vda_pkg::t_cfg      r_cfg;
    vda_pkg::t_state    r_st;
    vda_pkg::t_state    n_st;
    vda_pkg::t_in_word  r_s1_word;
    logic               r_s1_valid;
    vda_pkg::t_out_word r_out_word;
    vda_pkg::t_out_word n_out_word;
    logic               r_out_valid;
    logic               w_adv;
    logic               w_accept;

    assign w_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    vda_step u_step (
        .i_state (r_st),
        .i_cfg   (r_cfg),
        .i_word  (r_s1_word),
        .o_state (n_st),
        .o_res   (n_out_word)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_beacon      <= 1'b0;
            r_cfg.beacon_wait_ticks <= vda_pkg::BEACON_WAIT_RST;
            r_cfg.poll_wait_ticks   <= vda_pkg::POLL_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vda_pkg::CFG_TRACK_BEACON: r_cfg.track_beacon      <= i_cfg_data[0];
                vda_pkg::CFG_BEACON_WAIT:  r_cfg.beacon_wait_ticks <= i_cfg_data;
                vda_pkg::CFG_POLL_WAIT:    r_cfg.poll_wait_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= vda_pkg::PH_IDLE;
            r_st.saved_channel <= vda_pkg::NO_CHANNEL;
            r_st.saved_net_id  <= vda_pkg::NO_NET_ID;
            r_st.saved_coord   <= '0;
            r_st.wait_count    <= '0;
            r_st.given_addr    <= vda_pkg::NO_ADDR;
            r_st.resp_denied   <= 1'b0;
            r_st.learned_ext   <= '0;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_word <= i_in.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    `VDA_ASSERT_NXT(a_confirm_idles, w_adv && n_out_word.action == vda_pkg::ACT_CONFIRM, r_st.phase == vda_pkg::PH_IDLE)
    `VDA_ASSERT_IMP(a_idle_clean, r_st.phase == vda_pkg::PH_IDLE, r_st.given_addr == vda_pkg::NO_ADDR && !r_st.resp_denied)
    `VDA_ASSERT_IMP(a_count_in_wait, r_st.phase != vda_pkg::PH_BEACON && r_st.phase != vda_pkg::PH_POLL, r_st.wait_count == 24'd0)
    `VDA_ASSERT_IMP(a_status_on_confirm, o_out.valid && o_out.data.action != vda_pkg::ACT_CONFIRM, o_out.data.confirm_status == vda_pkg::ST_SUCCESS)
    `VDA_ASSERT_NXT(a_event_held, r_s1_valid && !w_adv, r_s1_valid)

endmodule

`default_nettype wire

// ===== tb/vlc_device_association_fsm_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// VLC device association sequencer: testbench
// Drives event words through the valid/ready channel with random gaps and
// result stalls. A scoreboard class models the association sequence and
// checks every result word field by field. The run covers several timer and
// beacon-tracking settings, directed corner events, and random sessions that
// mostly follow the procedure, with out-of-turn noise mixed in.
// ---------------------------------------------------------------------------
module vlc_device_association_fsm_tb;
    import vda_pkg::*;

    localparam logic [2:0] CMD_RESERVED  = 3'd7;
    localparam logic [1:0] TX_RESERVED   = 2'd3;
    localparam logic [1:0] RESP_RESERVED = 2'd3;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    class assoc_scoreboard;
        t_cfg      cfg;
        t_state    st;
        t_out_word due_results[$];
        int        errors;

        function new();
            cfg = '{track_beacon: 1'b0, beacon_wait_ticks: BEACON_WAIT_RST,
                    poll_wait_ticks: POLL_WAIT_RST};
            st.saved_coord = '0;
            st.learned_ext = '0;
            errors = 0;
            end_session();
        endfunction

        function void end_session();
            st.phase         = PH_IDLE;
            st.saved_channel = NO_CHANNEL;
            st.saved_net_id  = NO_NET_ID;
            st.wait_count    = '0;
            st.given_addr    = NO_ADDR;
            st.resp_denied   = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] value);
            case (idx)
                CFG_TRACK_BEACON: cfg.track_beacon      = value[0];
                CFG_BEACON_WAIT:  cfg.beacon_wait_ticks = value;
                CFG_POLL_WAIT:    cfg.poll_wait_ticks   = value;
                default: ;
            endcase
        endfunction

        function t_out_word addressed(t_out_word r, logic [2:0] act);
            r.action      = act;
            r.dest_addr   = st.saved_coord;
            r.dest_net_id = st.saved_net_id;
            r.use_channel = st.saved_channel;
            return r;
        endfunction

        function t_out_word confirm(t_out_word r, logic [2:0] status);
            if (status == ST_SUCCESS) begin
                r = addressed(r, ACT_CONFIRM);
                r.short_addr = st.given_addr;
            end
            r.action         = ACT_CONFIRM;
            r.confirm_status = status;
            end_session();
            return r;
        endfunction

        function logic tick_expired(logic [23:0] limit);
            st.wait_count = st.wait_count + 24'd1;
            return st.wait_count >= limit;
        endfunction

        function logic [2:0] tx_fail(logic [1:0] tx);
            return (tx == TX_ACCESS_FAIL) ? ST_ACCESS_FAIL : ST_NO_ACK;
        endfunction

        function void note_event(t_in_word w);
            t_out_word r;
            r = '0;
            r.short_addr = NO_ADDR;
            case (w.cmd)
                CMD_START: if (st.phase == PH_IDLE) begin
                    st.saved_channel = w.channel;
                    st.saved_net_id  = w.net_id;
                    st.saved_coord   = w.coord_addr;
                    st.phase         = PH_TX_REQ;
                    r = addressed(r, ACT_ASSOC_REQ);
                end
                CMD_TX_RESULT: begin
                    if (st.phase == PH_TX_REQ) begin
                        if (w.tx_status == TX_SUCCESS) begin
                            st.wait_count = '0;
                            st.phase = cfg.track_beacon ? PH_BEACON : PH_POLL;
                        end else begin
                            r = confirm(r, tx_fail(w.tx_status));
                        end
                    end else if (st.phase == PH_TX_DATA) begin
                        if (w.tx_status != TX_SUCCESS) begin
                            r = confirm(r, tx_fail(w.tx_status));
                        end else if (w.ack_pending) begin
                            st.phase = PH_RX_GRANT;
                            r = addressed(r, ACT_RX_SLOT);
                        end else begin
                            r = confirm(r, ST_NO_DATA);
                        end
                    end else if (st.phase == PH_TX_ACK) begin
                        r = confirm(r, st.resp_denied ? ST_DENIED : ST_SUCCESS);
                    end
                end
                CMD_BEACON: if (st.phase == PH_BEACON && w.listed_in_beacon) begin
                    st.wait_count = '0;
                    st.phase = PH_TX_DATA;
                    r = addressed(r, ACT_DATA_REQ);
                end
                CMD_GRANT: begin
                    if (st.phase == PH_RX_GRANT) begin
                        st.phase = PH_RESP;
                    end else if (st.phase == PH_ACK_GRANT) begin
                        st.phase = PH_TX_ACK;
                        r = addressed(r, ACT_SEND_ACK);
                    end
                end
                CMD_RESP: if (st.phase == PH_RESP) begin
                    if (w.resp_status == RESP_SUCCESS) begin
                        st.given_addr  = w.resp_short_addr;
                        st.learned_ext = w.resp_coord_ext;
                        st.resp_denied = 1'b0;
                    end else begin
                        st.given_addr  = NO_ADDR;
                        st.resp_denied = 1'b1;
                    end
                    st.phase = PH_ACK_GRANT;
                    r = addressed(r, ACT_ACK_SLOT);
                end
                CMD_TICK: begin
                    if (st.phase == PH_BEACON) begin
                        if (tick_expired(cfg.beacon_wait_ticks))
                            r = confirm(r, ST_NO_DATA);
                    end else if (st.phase == PH_POLL) begin
                        if (tick_expired(cfg.poll_wait_ticks)) begin
                            st.wait_count = '0;
                            st.phase = PH_TX_DATA;
                            r = addressed(r, ACT_DATA_REQ);
                        end
                    end
                end
                default: ;
            endcase
            r.coord_ext_addr = st.learned_ext;
            r.busy_res       = (st.phase != PH_IDLE);
            due_results.push_back(r);
        endfunction

        task report(string what);
            if (errors < 100)
                $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h, expected %0h", field, got, want));
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (due_results.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = due_results.pop_front();
                compare("action", 64'(got.action), 64'(want.action));
                compare("dest_addr", got.dest_addr, want.dest_addr);
                compare("dest_net_id", 64'(got.dest_net_id), 64'(want.dest_net_id));
                compare("use_channel", 64'(got.use_channel), 64'(want.use_channel));
                compare("confirm_status", 64'(got.confirm_status),
                        64'(want.confirm_status));
                compare("short_addr", 64'(got.short_addr), 64'(want.short_addr));
                compare("coord_ext_addr", got.coord_ext_addr, want.coord_ext_addr);
                compare("busy_res", 64'(got.busy_res), 64'(want.busy_res));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        calm;

    vda_in_if  in_if ();
    vda_out_if out_if ();

    assoc_scoreboard board = new();

    vlc_device_association_fsm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result(out_if.data);
    end

    function automatic t_in_word ev(logic [2:0] c, logic [1:0] st = TX_SUCCESS,
                                    logic flag = 1'b0);
        t_in_word w;
        w = '0;
        w.cmd              = c;
        w.tx_status        = st;
        w.resp_status      = st;
        w.ack_pending      = flag;
        w.listed_in_beacon = flag;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.cmd              = 3'($urandom_range(7));
        w.channel          = 8'($urandom);
        w.net_id           = 16'($urandom);
        w.coord_addr       = {$urandom, $urandom};
        w.coord_addr_mode  = 2'($urandom);
        w.tx_status        = 2'($urandom);
        w.ack_pending      = 1'($urandom);
        w.listed_in_beacon = 1'($urandom);
        w.resp_status      = 2'($urandom);
        w.resp_short_addr  = 16'($urandom);
        w.resp_coord_ext   = {$urandom, $urandom};
        return w;
    endfunction

    // mostly the word the procedure expects next, with random content
    function automatic t_in_word next_event(logic [3:0] ph, bit clean);
        t_in_word w;
        w = random_word();
        if (!clean && $urandom_range(99) < 12)
            return w;
        case (ph)
            PH_IDLE: w.cmd = CMD_START;
            PH_TX_REQ, PH_TX_DATA, PH_TX_ACK: begin
                w.cmd = CMD_TX_RESULT;
                if ($urandom_range(99) < 80)
                    w.tx_status = TX_SUCCESS;
                if ($urandom_range(99) < 75)
                    w.ack_pending = 1'b1;
            end
            PH_BEACON: w.cmd = ($urandom_range(99) < 40) ? CMD_TICK : CMD_BEACON;
            PH_POLL: w.cmd = CMD_TICK;
            PH_RX_GRANT, PH_ACK_GRANT: w.cmd = CMD_GRANT;
            PH_RESP: begin
                w.cmd = CMD_RESP;
                if ($urandom_range(99) < 65)
                    w.resp_status = RESP_SUCCESS;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic push_event(input t_in_word w);
        while (!calm && $urandom_range(99) < 13) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        board.note_event(w);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(logic track, logic [23:0] beacon_wait,
                             logic [23:0] poll_wait);
        logic [23:0] track_data;
        logic [23:0] junk;
        track_data    = 24'($urandom);
        track_data[0] = track;
        junk          = 24'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TRACK_BEACON;
        i_cfg_data <= track_data;
        @(posedge i_clk);
        board.set_reg(CFG_TRACK_BEACON, track_data);
        i_cfg_idx  <= CFG_BEACON_WAIT;
        i_cfg_data <= beacon_wait;
        @(posedge i_clk);
        board.set_reg(CFG_BEACON_WAIT, beacon_wait);
        i_cfg_idx  <= CFG_POLL_WAIT;
        i_cfg_data <= poll_wait;
        @(posedge i_clk);
        board.set_reg(CFG_POLL_WAIT, poll_wait);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= junk;
        @(posedge i_clk);
        board.set_reg(CFG_UNUSED, junk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // random events; once the count of events is reached, the open session is closed
    task automatic run_sessions(int count);
        int n;
        n = 0;
        while (n < count || board.st.phase != PH_IDLE) begin
            push_event(next_event(board.st.phase, n >= count));
            n++;
        end
    endtask

    initial begin
        t_in_word w;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        calm         <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: odd command, all-ones start, start while busy, tx failures
        push_event(ev(CMD_RESERVED));
        w = '1;
        w.cmd = CMD_START;
        push_event(w);
        push_event(ev(CMD_START));
        push_event(ev(CMD_TX_RESULT, TX_ACCESS_FAIL));
        push_event(ev(CMD_START));
        push_event(ev(CMD_TX_RESULT, TX_RESERVED));
        settle();

        // zero poll wait fires on the first tick
        configure(1'b0, 24'd0, 24'd0);
        push_event(ev(CMD_START));
        push_event(ev(CMD_TX_RESULT));
        push_event(ev(CMD_TICK));
        push_event(ev(CMD_TX_RESULT, TX_SUCCESS, 1'b0));
        push_event(ev(CMD_START));
        push_event(ev(CMD_TX_RESULT));
        push_event(ev(CMD_TICK));
        push_event(ev(CMD_TX_RESULT, TX_SUCCESS, 1'b1));
        push_event(ev(CMD_TICK));
        push_event(ev(CMD_GRANT));
        push_event(ev(CMD_RESP, RESP_RESERVED));
        push_event(ev(CMD_GRANT));
        push_event(ev(CMD_TX_RESULT, TX_ACCESS_FAIL));
        settle();

        // beacon tracking: unlisted beacon, then timeout
        configure(1'b1, 24'd0, 24'd0);
        push_event(ev(CMD_START));
        push_event(ev(CMD_TX_RESULT));
        push_event(ev(CMD_BEACON, TX_SUCCESS, 1'b0));
        push_event(ev(CMD_TICK));
        settle();

        configure(1'b0, 24'($urandom_range(1, 10)), 24'($urandom_range(1, 12)));
        run_sessions(250);
        settle();
        configure(1'b1, 24'($urandom_range(1, 10)), 24'($urandom_range(1, 5000)));
        run_sessions(250);
        settle();
        configure(1'b1, 24'hffffff, 24'hffffff);
        run_sessions(200);
        settle();
        configure(1'b0, 24'd0, 24'd0);
        run_sessions(200);
        settle();
        configure(1'b1, 24'd0, 24'($urandom_range(1, 40)));
        run_sessions(150);
        settle();
        calm <= 1'b1;
        configure(1'b0, 24'($urandom_range(1, 40)), 24'($urandom_range(1, 40)));
        run_sessions(350);
        settle();
        repeat (10) @(posedge i_clk);

        if (board.errors == 0)
            $display("vlc_device_association_fsm_tb: done, clean");
        else
            $display("vlc_device_association_fsm_tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("vlc_device_association_fsm_tb: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/vda_pkg.sv
sv/vda_in_if.sv
sv/vda_out_if.sv
sv/vda_step.sv
sv/vlc_device_association_fsm.sv
tb/vlc_device_association_fsm_tb.sv
